// ===== hw/rtl/wildcard_byte_pattern_scanner_assert.svh =====
// Assertion macros for the wildcard byte pattern scanner checker.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define WBPS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define WBPS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/wbps_pkg.sv =====
// Constants and register codes of the wildcard byte pattern scanner.
package wbps_pkg;

	localparam int REG_BYTES = 32;
	localparam int PAT_IDX_W = 5;
	localparam int LEN_W = 6;
	localparam int DATA_W = 64;
	localparam int ADDR_W = 6;
	localparam int REG_IDX_W = 3;
	localparam int OUT_W = 48;

	localparam logic [7:0] WILDCARD = 8'hCC;
	localparam logic [31:0] OFFSET_SAT = 32'hFFFF_FFFF;
	localparam logic [15:0] REGION_SAT = 16'hFFFF;

	localparam logic [REG_IDX_W-1:0] REG_PAT_A = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PAT_B = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PAT_C = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_PAT_D = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_LEN = 3'd4;

endpackage

// ===== hw/rtl/wbps_match.sv =====
// Parallel wildcard compare of the aligned pattern against the byte history.
module wbps_match #(
	parameter int LIM = 32
) (
	input logic [LIM-1:0][7:0] align,
	input logic [LIM-1:0][7:0] hist,
	output logic all_match
);
	import wbps_pkg::*;

	logic [LIM-1:0] ok;

	always_comb begin
		for (int j = 0; j < LIM; j++) begin
			ok[j] = (align[j] == WILDCARD) || (align[j] == hist[j]);
		end
	end

	assign all_match = &ok;

endmodule

// ===== hw/rtl/wildcard_byte_pattern_scanner.sv =====
// Top level of the wildcard byte pattern scanner.
//
// Channel   Dir  Contents
// s_*       in   tdata[7:0] data_byte, tuser region_first, tlast scan_last
// m_*       out  tdata[15:0] region_number, tdata[47:16] match_offset, tuser found
// APB       in   pattern words at 0x00..0x18, pattern length at 0x20
//
// One word is taken per cycle while the input is not stalled; each word sits in the input register,
// where the full pattern compare and counter update happen, then at most one
// result moves to the output register. The output register decouples the two
// sides, so input stalls only when the input register is full, a result word is
// waiting and m_tready is low.
// Reset clears the handshake and scan state; the scan then starts in region 0.
module wildcard_byte_pattern_scanner #(
	parameter int PATTERN_MAX = 32
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [wbps_pkg::ADDR_W-1:0] paddr,
	input logic [wbps_pkg::DATA_W-1:0] pwdata,
	output logic [wbps_pkg::DATA_W-1:0] prdata,
	output logic pready,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata,    // data_byte
	input logic s_tuser,          // region_first
	input logic s_tlast,          // scan_last
	output logic m_tvalid,
	input logic m_tready,
	output logic [wbps_pkg::OUT_W-1:0] m_tdata, // region_number, match_offset
	output logic m_tuser          // found
);
	import wbps_pkg::*;

	localparam int LIM = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;
	localparam int WIN = (LIM > 1) ? LIM - 1 : 1;

	logic [3:0][63:0] pat_q;
	logic [LEN_W-1:0] plen_q;
	logic [REG_BYTES-1:0][7:0] pat_bytes;
	logic [REG_IDX_W-1:0] reg_idx;
	logic cfg_wr;

	logic [LEN_W-1:0] len_c;
	logic [LEN_W-1:0] len_q;
	logic [LIM-1:0][7:0] align_c;
	logic [LIM-1:0][7:0] align_q;

	logic s1_valid;
	logic [7:0] byte_s1;
	logic first_s1;
	logic last_s1;

	logic [WIN-1:0][7:0] win_q;
	logic [31:0] bir_q;
	logic [15:0] rc_q;
	logic done_q;
	logic open_q;

	logic out_valid_q;
	logic found_q;
	logic [15:0] region_q;
	logic [31:0] offset_q;

	logic advance;
	logic clr;
	logic [WIN-1:0][7:0] win_eff;
	logic [WIN-1:0][7:0] win_n;
	logic [LIM-1:0][7:0] hist;
	logic [31:0] bir_base;
	logic [31:0] bir_new;
	logic [15:0] rc_next;
	logic pat_ok;
	logic hit;
	logic emit;
	logic [31:0] offset;

	assign pready = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pat_bytes = pat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= '0;
			plen_q <= LEN_W'(1);
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_PAT_A, REG_PAT_B, REG_PAT_C, REG_PAT_D: pat_q[reg_idx[1:0]] <= pwdata;
				REG_LEN: plen_q <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PAT_A, REG_PAT_B, REG_PAT_C, REG_PAT_D: prdata = pat_q[reg_idx[1:0]];
			REG_LEN: prdata = {{(DATA_W-LEN_W){1'b0}}, plen_q};
			default: prdata = '0;
		endcase
	end

	// The pattern is stored reversed against the history, so that entry 0 meets
	// the newest byte; entries past the active length are wildcards.
	assign len_c = (plen_q > LEN_W'(LIM)) ? LEN_W'(LIM) : plen_q;

	always_comb begin
		for (int j = 0; j < LIM; j++) begin
			if (LEN_W'(j) < len_c) begin
				align_c[j] = pat_bytes[PAT_IDX_W'(len_c - LEN_W'(j) - LEN_W'(1))];
			end else begin
				align_c[j] = WILDCARD;
			end
		end
	end

	always_ff @(posedge clk) begin
		align_q <= align_c;
		len_q <= len_c;
	end

	assign advance = s1_valid && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			first_s1 <= s_tuser;
			last_s1 <= s_tlast;
		end
	end

	assign clr = !open_q || first_s1;
	assign win_eff = clr ? '0 : win_q;
	assign bir_base = clr ? 32'd0 : bir_q;
	assign bir_new = (bir_base == OFFSET_SAT) ? OFFSET_SAT : bir_base + 32'd1;

	always_comb begin
		if (!open_q) begin
			rc_next = '0;
		end else if (first_s1 && rc_q != REGION_SAT) begin
			rc_next = rc_q + 16'd1;
		end else begin
			rc_next = rc_q;
		end
	end

	always_comb begin
		hist[0] = byte_s1;
		for (int j = 1; j < LIM; j++) begin
			hist[j] = win_eff[j-1];
		end
		win_n[0] = byte_s1;
		for (int k = 1; k < WIN; k++) begin
			win_n[k] = win_eff[k-1];
		end
	end

	wbps_match #(
		.LIM(LIM)
	) u_match (
		.align(align_q),
		.hist(hist),
		.all_match(pat_ok)
	);

	assign hit = !done_q && (bir_new >= 32'(len_q)) && pat_ok;
	assign emit = hit || (last_s1 && !done_q);

	always_comb begin
		if (bir_new == OFFSET_SAT) begin
			offset = OFFSET_SAT;
		end else if (len_q == '0) begin
			offset = bir_new - 32'd1;
		end else begin
			offset = bir_new - 32'(len_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			open_q <= 1'b0;
		end else if (advance) begin
			done_q <= last_s1 ? 1'b0 : (done_q || hit);
			open_q <= !last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			win_q <= win_n;
			bir_q <= bir_new;
			rc_q <= rc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			found_q <= hit;
			region_q <= hit ? rc_next : 16'd0;
			offset_q <= hit ? offset : 32'd0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {offset_q, region_q};
	assign m_tuser = found_q;

endmodule

// ===== hw/rtl/wbps_checker.sv =====
// Port-level checker for the wildcard byte pattern scanner, with its bind.
`include "wildcard_byte_pattern_scanner_assert.svh"

module wbps_checker (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [wbps_pkg::ADDR_W-1:0] paddr,
	input logic [wbps_pkg::DATA_W-1:0] pwdata,
	input logic [wbps_pkg::DATA_W-1:0] prdata,
	input logic pready,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [wbps_pkg::OUT_W-1:0] m_tdata,
	input logic m_tuser
);
	import wbps_pkg::*;

	logic len_wr;
	logic len_rd;

	assign len_wr = psel && penable && pwrite && pready && (paddr[5:3] == REG_LEN);
	assign len_rd = psel && !pwrite && (paddr[5:3] == REG_LEN);

	`WBPS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "Stalled result word changed.")
	`WBPS_ASSERT_IMP(a_notfound_zero, m_tvalid && !m_tuser, m_tdata == '0, "Not-found word carries a nonzero payload.")
	`WBPS_ASSERT_IMP(a_ready_when_empty, !m_tvalid, s_tready, "Input stalled while the output register is empty.")
	`WBPS_ASSERT_IMP(a_len_readback, $past(len_wr) && len_rd, prdata[5:0] == $past(pwdata[5:0]), "Pattern length readback differs from the written value.")

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (.*);

// ===== test/wildcard_byte_pattern_scanner_tb.sv =====
// Self-checking testbench for the wildcard byte pattern scanner, driven by directed and random scans.
`timescale 1ns / 100ps

module wildcard_byte_pattern_scanner_tb;
	import wbps_pkg::*;

	localparam int TIMEOUT_NS = 2_000_000;
	localparam int RANDOM_WORDS = 420;
	localparam int PHASE_WORDS = 45;
	localparam int HOLD_CYCLES = 60;
	localparam logic [REG_IDX_W-1:0] REG_VOID = REG_LEN + 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_VOID_TOP = '1;

	typedef struct packed {
		logic found;
		logic [15:0] region;
		logic [31:0] offset;
	} report_t;

	typedef enum logic {ROW_WRITE, ROW_WORD} row_kind_t;
	typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_TYPED} chk_t;

	typedef struct packed {
		row_kind_t kind;
		logic [REG_IDX_W-1:0] idx;
		logic [DATA_W-1:0] value;
		logic [7:0] data;
		logic first;
		logic last;
		chk_t chk;
		report_t rep;
	} dir_row_t;

	localparam int DIR_ROWS = 29;
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		'{ROW_WORD, REG_PAT_A, 64'd0, 8'h00, 1'b1, 1'b1, CHK_TYPED, '{1'b1, 16'd0, 32'd0}},
		'{ROW_WORD, REG_PAT_A, 64'd0, 8'hFF, 1'b0, 1'b1, CHK_TYPED, '{1'b0, 16'd0, 32'd0}},
		'{ROW_WRITE, REG_LEN, 64'd0, 8'h00, 1'b0, 1'b0, CHK_NONE, '0},
		'{ROW_WORD, REG_PAT_A, 64'd0, 8'h5A, 1'b0, 1'b0, CHK_TYPED, '{1'b1, 16'd0, 32'd0}},
		'{ROW_WORD, REG_PAT_A, 64'd0, 8'h12, 1'b1, 1'b1, CHK_NONE, '0},
		'{ROW_WRITE, REG_PAT_A, 64'h42_CC41, 8'h00, 1'b0, 1'b0, CHK_NONE, '0},
		'{ROW_WRITE, REG_LEN, 64'd3, 8'h00, 1'b0, 1'b0, CHK_NONE, '0},
		'{ROW_WRITE, REG_VOID, 64'd1, 8'h00, 1'b0, 1'b0, CHK_NONE, '0},
		'{ROW_WRITE, REG_VOID_TOP, '1, 8'h00, 1'b0, 1'b0, CHK_NONE, '0},
		'{ROW_WORD, REG_PAT_A, 64'd0, 8'h41, 1'b1, 1'b0, CHK_NONE, '0},
		'{ROW_WORD, REG_PAT_A, 64'd0, 8'h00, 1'b0, 1'b0, CHK_NONE, '0},
		'{ROW_WORD, REG_PAT_A, 64'd0, 8'h41, 1'b1, 1'b0, CHK_NONE, '0},
		'{ROW_WORD, REG_PAT_A, 64'd0, 8'h41, 1'b1, 1'b0, CHK_NONE, '0},
		'{ROW_WORD, REG_PAT_A, 64'd0, 8'h99, 1'b0, 1'b0, CHK_NONE, '0},
		'{ROW_WORD, REG_PAT_A, 64'd0, 8'h42, 1'b0, 1'b0, CHK_TYPED, '{1'b1, 16'd2, 32'd0}},
		'{ROW_WORD, REG_PAT_A, 64'd0, 8'h41, 1'b0, 1'b1, CHK_NONE, '0},
		'{ROW_WORD, REG_PAT_A, 64'd0, 8'h41, 1'b0, 1'b1, CHK_TYPED, '{1'b0, 16'd0, 32'd0}},
		'{ROW_WORD, REG_PAT_A, 64'd0, 8'hCC, 1'b0, 1'b0, CHK_NONE, '0},
		'{ROW_WORD, REG_PAT_A, 64'd0, 8'hCC, 1'b0, 1'b0, CHK_NONE, '0},
		'{ROW_WORD, REG_PAT_A, 64'd0, 8'hCC, 1'b0, 1'b1, CHK_TYPED, '{1'b0, 16'd0, 32'd0}},
		'{ROW_WORD, REG_PAT_A, 64'd0, 8'h7F, 1'b1, 1'b0, CHK_NONE, '0},
		'{ROW_WORD, REG_PAT_A, 64'd0, 8'h41, 1'b0, 1'b0, CHK_NONE, '0},
		'{ROW_WORD, REG_PAT_A, 64'd0, 8'h80, 1'b0, 1'b0, CHK_NONE, '0},
		'{ROW_WORD, REG_PAT_A, 64'd0, 8'h42, 1'b0, 1'b1, CHK_TYPED, '{1'b1, 16'd0, 32'd1}},
		'{ROW_WORD, REG_PAT_A, 64'd0, 8'h41, 1'b0, 1'b0, CHK_NONE, '0},
		'{ROW_WORD, REG_PAT_A, 64'd0, 8'h55, 1'b0, 1'b0, CHK_NONE, '0},
		'{ROW_WORD, REG_PAT_A, 64'd0, 8'h42, 1'b1, 1'b1, CHK_TYPED, '{1'b0, 16'd0, 32'd0}},
		'{ROW_WRITE, REG_PAT_A, '1, 8'h00, 1'b0, 1'b0, CHK_NONE, '0},
		'{ROW_WORD, REG_PAT_A, 64'd0, 8'hFF, 1'b0, 1'b1, CHK_PREDICT, '0}
	};

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic s_tvalid;
	logic s_tready;
	logic [7:0] s_tdata;    // data_byte
	logic s_tuser;          // region_first
	logic s_tlast;          // scan_last
	logic m_tvalid;
	logic m_tready;
	logic [OUT_W-1:0] m_tdata; // region_number, match_offset
	logic m_tuser;          // found

	logic [DATA_W-1:0] pat_words_cfg [4];
	logic [LEN_W-1:0] pat_len_cfg;
	logic [7:0] recent_bytes [32];
	logic [31:0] region_bytes;
	logic [15:0] region_idx;
	logic hit_reported;
	logic scan_active;

	report_t pending_reports [$];
	int fail_count;
	int random_words;
	logic gaps_on;
	logic stalls_on;
	logic hold_req;

	wildcard_byte_pattern_scanner uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [7:0] pattern_at(input int idx);
		return pat_words_cfg[idx / 8][(idx % 8) * 8 +: 8];
	endfunction

	function automatic int active_len();
		return (pat_len_cfg > REG_BYTES) ? REG_BYTES : int'(pat_len_cfg);
	endfunction

	function automatic logic scan_byte_predict(input logic [7:0] cur, input logic first,
			input logic last, output report_t rep);
		int len;
		int i;
		logic hit;
		logic [7:0] pb;
		logic [7:0] db;
		len = active_len();
		hit = 1'b0;
		rep = '0;
		if (!scan_active) begin
			scan_active = 1'b1;
			recent_bytes = '{default: '0};
			region_bytes = '0;
			region_idx = '0;
		end else if (first) begin
			recent_bytes = '{default: '0};
			region_bytes = '0;
			if (region_idx != REGION_SAT)
				region_idx++;
		end
		if (region_bytes != OFFSET_SAT)
			region_bytes++;
		if (!hit_reported && region_bytes >= len) begin
			hit = 1'b1;
			for (i = 0; i < len; i++) begin
				pb = pattern_at(i);
				if (i == len - 1)
					db = cur;
				else
					db = recent_bytes[len - 2 - i];
				if (pb != WILDCARD && pb != db)
					hit = 1'b0;
			end
		end
		for (i = 31; i > 0; i--)
			recent_bytes[i] = recent_bytes[i - 1];
		recent_bytes[0] = cur;
		if (hit) begin
			hit_reported = 1'b1;
			rep.found = 1'b1;
			rep.region = region_idx;
			if (region_bytes == OFFSET_SAT)
				rep.offset = OFFSET_SAT;
			else if (len == 0)
				rep.offset = region_bytes - 1;
			else
				rep.offset = region_bytes - len;
		end
		scan_byte_predict = hit || (last && !hit_reported);
		if (last) begin
			recent_bytes = '{default: '0};
			region_bytes = '0;
			region_idx = '0;
			hit_reported = 1'b0;
			scan_active = 1'b0;
		end
	endfunction

	task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 3'b000};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		if (idx <= REG_PAT_D)
			pat_words_cfg[idx[1:0]] = val;
		else if (idx == REG_LEN)
			pat_len_cfg = val[LEN_W-1:0];
	endtask

	task automatic wait_idle();
		s_tvalid = 1'b0;
		while (pending_reports.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic put_byte(input logic [7:0] d, input logic first, input logic last,
			input chk_t chk, input report_t typed);
		report_t rep;
		logic has;
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = d;
		s_tuser = first;
		s_tlast = last;
		do @(posedge clk); while (!s_tready);
		has = scan_byte_predict(d, first, last, rep);
		if (chk == CHK_TYPED)
			pending_reports.push_back(typed);
		else if (chk == CHK_PREDICT && has)
			pending_reports.push_back(rep);
		@(negedge clk);
	endtask

	task automatic random_scan();
		int len;
		int nreg;
		int plant_reg;
		int rlen;
		int pos;
		int r;
		int j;
		logic [7:0] pb;
		logic [7:0] b;
		logic first;
		len = active_len();
		nreg = $urandom_range(1, 4);
		plant_reg = ($urandom_range(0, 9) < 7) ? $urandom_range(0, nreg - 1) : -1;
		for (r = 0; r < nreg; r++) begin
			rlen = $urandom_range(1, len + 6);
			if (r == plant_reg && rlen < len)
				rlen = len;
			pos = (rlen > len) ? $urandom_range(0, rlen - len) : 0;
			for (j = 0; j < rlen; j++) begin
				if (r == plant_reg && j >= pos && j < pos + len) begin
					pb = pattern_at(j - pos);
					b = (pb == WILDCARD) ? 8'($urandom_range(0, 255)) : pb;
				end else begin
					case ($urandom_range(0, 3))
						0: b = 8'($urandom_range(0, 255));
						1: b = WILDCARD;
						default: begin
							b = (len > 0) ? pattern_at($urandom_range(0, len - 1))
								: 8'($urandom_range(0, 255));
						end
					endcase
				end
				first = (j == 0) && (r > 0 || $urandom_range(0, 1) == 1);
				put_byte(b, first, (r == nreg - 1) && (j == rlen - 1), CHK_PREDICT, '0);
				random_words++;
			end
		end
	endtask

	task automatic random_pattern(input int len_mode);
		int k;
		int w;
		logic [DATA_W-1:0] word;
		for (w = 0; w < 4; w++) begin
			for (k = 0; k < 8; k++) begin
				case ($urandom_range(0, 3))
					0, 1: word[k * 8 +: 8] = WILDCARD;
					2: word[k * 8 +: 8] = 8'($urandom_range(0, 3));
					default: word[k * 8 +: 8] = 8'($urandom_range(0, 255));
				endcase
			end
			cfg_write(REG_PAT_A + w[REG_IDX_W-1:0], word);
		end
		case (len_mode)
			0: cfg_write(REG_LEN, 64'd0);
			1: cfg_write(REG_LEN, 64'd32);
			2: cfg_write(REG_LEN, 64'($urandom_range(33, 63)));
			default: cfg_write(REG_LEN, 64'($urandom_range(1, 8)));
		endcase
	endtask

	initial begin
		#TIMEOUT_NS;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (stalls_on && $urandom_range(0, 5) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(0, 4)) @(negedge clk);
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		report_t rep;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reports.size() == 0) begin
				$error("unexpected result: found %0d, region %0d, offset %0d",
					m_tuser, m_tdata[15:0], m_tdata[47:16]);
				fail_count++;
			end else begin
				rep = pending_reports.pop_front();
				if (m_tuser !== rep.found) begin
					$error("found: expected %0d, actual %0d", rep.found, m_tuser);
					fail_count++;
				end
				if (m_tdata[15:0] !== rep.region) begin
					$error("region_number: expected %0d, actual %0d", rep.region, m_tdata[15:0]);
					fail_count++;
				end
				if (m_tdata[47:16] !== rep.offset) begin
					$error("match_offset: expected %0d, actual %0d", rep.offset, m_tdata[47:16]);
					fail_count++;
				end
			end
		end
	end

	initial begin
		int row;
		int phase;
		int phase_start;
		int k;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		s_tlast = 1'b0;
		fail_count = 0;
		random_words = 0;
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		hold_req = 1'b0;
		pat_words_cfg = '{default: '0};
		pat_len_cfg = 6'd1;
		recent_bytes = '{default: '0};
		region_bytes = '0;
		region_idx = '0;
		hit_reported = 1'b0;
		scan_active = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (row = 0; row < DIR_ROWS; row++) begin
			if (DIR_TABLE[row].kind == ROW_WRITE) begin
				wait_idle();
				cfg_write(DIR_TABLE[row].idx, DIR_TABLE[row].value);
			end else begin
				put_byte(DIR_TABLE[row].data, DIR_TABLE[row].first, DIR_TABLE[row].last,
					DIR_TABLE[row].chk, DIR_TABLE[row].rep);
			end
		end

		// One-word scans pile up behind a long receiver stall.
		wait_idle();
		cfg_write(REG_LEN, 64'd1);
		cfg_write(REG_PAT_A, 64'($urandom_range(0, 255)));
		gaps_on = 1'b0;
		hold_req = 1'b1;
		repeat (24)
			put_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, CHK_PREDICT, '0);

		phase = 0;
		while (random_words < RANDOM_WORDS) begin
			wait_idle();
			case (phase)
				0: begin
					for (k = 0; k < 4; k++)
						cfg_write(REG_PAT_A + k[REG_IDX_W-1:0], '1);
					cfg_write(REG_LEN, 64'd32);
				end
				1: begin
					for (k = 0; k < 4; k++)
						cfg_write(REG_PAT_A + k[REG_IDX_W-1:0], '0);
					cfg_write(REG_LEN, 64'd1);
				end
				2: random_pattern(2);
				3: random_pattern(0);
				4: random_pattern(1);
				default: random_pattern($urandom_range(0, 9));
			endcase
			gaps_on = ($urandom_range(0, 3) != 0);
			stalls_on = ($urandom_range(0, 3) != 0);
			phase_start = random_words;
			while (random_words - phase_start < PHASE_WORDS)
				random_scan();
			phase++;
		end

		// The closing scans run with no idling on either side.
		wait_idle();
		random_pattern(3);
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		phase_start = random_words;
		while (random_words - phase_start < PHASE_WORDS)
			random_scan();
		s_tvalid = 1'b0;

		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
